FILE: rtl/core/iirl_pkg.sv
// Shared types and constants for the indexed insert/remove list.
`default_nettype none
package iirl_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;

    localparam int OP_W   = 3;
    localparam int IDX_W  = 5;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int SIZE_W = 5;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [CMP_W-1:0]      t_pos;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_APPEND  = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_GET     = 3'd3,
        OP_CRESET  = 3'd4,
        OP_GETNEXT = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        logic ins;
        logic rem;
        t_pos pos;
    } t_shift_ctl;

    typedef struct packed {
        t_status           status;
        logic              rd_en;
        t_pos              rd_addr;
        logic [SIZE_W-1:0] size;
        logic              at_end;
    } t_step_res;

endpackage
`default_nettype wire

FILE: rtl/core/iirl_in_if.sv
// Operation channel: op, index and value with valid/ready.
`default_nettype none
interface iirl_in_if
    import iirl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/iirl_out_if.sv
// Result channel: status, read value, size and end flag with valid/ready.
`default_nettype none
interface iirl_out_if
    import iirl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [VAL_W-1:0]  read_value;
    logic [SIZE_W-1:0] size;
    logic              at_end;

    modport source (output valid, output status, output read_value, output size,
                    output at_end, input ready);
    modport sink   (input valid, input status, input read_value, input size,
                    input at_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/iirl_cell.sv
// One storage cell of the list chain: hold, load, or take a neighbor's word.
`default_nettype none
module iirl_cell
    import iirl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire t_word     i_new,
    input  wire t_word     i_left,
    input  wire t_word     i_right,
    output t_word          o_word
);

    t_word r_word;
    t_word n_word;

    always_comb begin
        unique case (i_cmd)
            CELL_HOLD:  n_word = r_word;
            CELL_LOAD:  n_word = i_new;
            CELL_LEFT:  n_word = i_left;
            CELL_RIGHT: n_word = i_right;
            default:    n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

FILE: rtl/core/iirl_ctrl.sv
// Operation decode, size and cursor registers, and per-step result fields.
`default_nettype none
module iirl_ctrl
    import iirl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [OP_W-1:0]  i_op,
    input  wire logic [IDX_W-1:0] i_index,
    output t_shift_ctl            o_shift,
    output t_step_res             o_res,
    output t_cnt                  o_count
);

    t_cnt  r_count;
    t_cnt  r_cursor;
    t_cnt  n_count;
    t_cnt  n_cursor;
    t_pos  w_idx;
    t_pos  w_cnt;
    t_pos  w_cur;
    logic  w_full;
    t_shift_ctl w_shift;
    t_step_res  w_res;

    assign w_idx  = CMP_W'(i_index);
    assign w_cnt  = CMP_W'(r_count);
    assign w_cur  = CMP_W'(r_cursor);
    assign w_full = (r_count >= CNT_W'(CAPACITY));

    always_comb begin
        w_shift        = '0;
        w_res          = '0;
        w_res.status   = ST_OK;
        n_count        = r_count;
        n_cursor       = r_cursor;
        unique case (t_op'(i_op))
            OP_INSERT: begin
                if (w_full) begin
                    w_res.status = ST_FULL;
                end else if (w_idx > w_cnt) begin
                    w_res.status = ST_BAD;
                end else begin
                    w_shift.ins = 1'b1;
                    w_shift.pos = w_idx;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            OP_APPEND: begin
                if (w_full) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_shift.ins = 1'b1;
                    w_shift.pos = w_cnt;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (w_idx >= w_cnt) begin
                    w_res.status = ST_BAD;
                end else begin
                    w_shift.rem = 1'b1;
                    w_shift.pos = w_idx;
                    n_count     = r_count - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (w_idx >= w_cnt) begin
                    w_res.status = ST_BAD;
                end else begin
                    w_res.rd_en   = 1'b1;
                    w_res.rd_addr = w_idx;
                end
            end
            OP_CRESET: begin
                n_cursor = '0;
            end
            OP_GETNEXT: begin
                if (r_cursor >= r_count) begin
                    w_res.status = ST_BAD;
                end else begin
                    w_res.rd_en   = 1'b1;
                    w_res.rd_addr = w_cur;
                    n_cursor      = r_cursor + CNT_W'(1);
                end
            end
            default: begin
                w_res.status = ST_BAD;
            end
        endcase
        w_res.size   = SIZE_W'(n_count);
        w_res.at_end = (n_cursor == n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else if (i_accept) begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    assign o_shift.ins = w_shift.ins & i_accept;
    assign o_shift.rem = w_shift.rem & i_accept;
    assign o_shift.pos = w_shift.pos;
    assign o_res       = w_res;
    assign o_count     = r_count;

endmodule
`default_nettype wire

FILE: rtl/core/indexed_insert_remove_list_top.sv
// Top level of the indexed insert/remove list: cell chain, read select, result register.
`default_nettype none
// The list lives in a row of CAPACITY cells, one word each; insert and remove
// move every cell at or above the chosen position at once, away from it or
// toward it, and a new operation is accepted every cycle as long as
// the result register is empty or its result is taken in the same cycle.
// Each operation gives exactly one result, registered in the cycle after it is accepted.
// Reset clears the size, the cursor and the result valid flag only; words are
// never read above the size, so the cells need no clearing.
module indexed_insert_remove_list_top
    import iirl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    iirl_in_if.sink    i_in,
    iirl_out_if.source o_out
);

    logic       w_accept;
    t_shift_ctl w_shift;
    t_step_res  w_res;
    t_cnt       w_count;
    t_word      w_new;
    t_word      w_words [CAPACITY];
    t_word      w_rd_terms [CAPACITY];
    t_word      w_rd_word;

    logic              r_valid;
    t_status           r_status;
    logic [VAL_W-1:0]  r_read_value;
    logic [SIZE_W-1:0] r_size;
    logic              r_at_end;

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_new      = WORD_WIDTH'(i_in.value);

    iirl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_op     (i_in.op),
        .i_index  (i_in.index),
        .o_shift  (w_shift),
        .o_res    (w_res),
        .o_count  (w_count)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_cmd w_cmd;
        t_word     w_left;
        t_word     w_right;
        t_pos      w_here;

        assign w_here = CMP_W'(g);

        always_comb begin
            w_cmd = CELL_HOLD;
            if (w_shift.ins) begin
                if (w_here > w_shift.pos) begin
                    w_cmd = CELL_LEFT;
                end else if (w_here == w_shift.pos) begin
                    w_cmd = CELL_LOAD;
                end
            end else if (w_shift.rem) begin
                if (w_here >= w_shift.pos) begin
                    w_cmd = CELL_RIGHT;
                end
            end
        end

        if (g == 0) begin : g_first
            assign w_left = w_new;
        end else begin : g_mid_l
            assign w_left = w_words[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_words[g];
        end else begin : g_mid_r
            assign w_right = w_words[g+1];
        end

        iirl_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_new   (w_new),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_words[g])
        );

        assign w_rd_terms[g] = (w_res.rd_addr == w_here) ? w_words[g] : '0;
    end

    always_comb begin
        w_rd_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_word = w_rd_word | w_rd_terms[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= w_res.status;
            r_read_value <= w_res.rd_en ? VAL_W'(w_rd_word) : '0;
            r_size       <= w_res.size;
            r_at_end     <= w_res.at_end;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.status     = r_status;
    assign o_out.read_value = r_read_value;
    assign o_out.size       = r_size;
    assign o_out.at_end     = r_at_end;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(CAPACITY))
        else $error("list size above capacity");

    a_one_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_shift.ins && w_shift.rem))
        else $error("insert and remove in the same cycle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_valid)
        else $error("accepted transfer produced no result");

    a_size_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (CNT_W'(r_size) == w_count))
        else $error("reported size differs from stored size");

    a_fail_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != ST_OK) |-> (r_read_value == '0))
        else $error("failed operation returned a read value");

endmodule
`default_nettype wire
